@@ rtl/button_click_longpress_detector_macros.svh @@
// Assertion macros for the keypad event detector.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef BUTTON_CLICK_LONGPRESS_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_LONGPRESS_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BCLP_ASSERT_NOW(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BCLP_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bclp_pkg.sv @@
// Shared types and constants for the keypad event detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package bclp_pkg;

  localparam int NUM_BUTTONS = 7;
  localparam int REF_BITS    = 6;   // tick reference up to 40 ms
  localparam int WIN_BITS    = 9;   // press window up to 8 * 40 ms

  // Transaction opcodes; code 3 behaves as a tick.
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_MENU = 2'd1;
  localparam logic [1:0] OP_CTRL = 2'd2;

  localparam logic [1:0] SPEED_SLOW   = 2'd0;
  localparam logic [1:0] SPEED_MEDIUM = 2'd1;

  localparam logic [REF_BITS-1:0] REF_SLOW   = REF_BITS'(40);
  localparam logic [REF_BITS-1:0] REF_MEDIUM = REF_BITS'(30);
  localparam logic [REF_BITS-1:0] REF_FAST   = REF_BITS'(20);

  localparam logic [WIN_BITS-1:0] CTRL_WINDOW = WIN_BITS'(5);

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_CLICK   = 3'd1,
    EV_DOUBLE  = 3'd2,
    EV_LPSTART = 3'd3,
    EV_LP      = 3'd4,
    EV_LPSTOP  = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DOWN     = 3'd1,
    PH_UP       = 3'd2,
    PH_COUNT    = 3'd3,
    PH_PRESS    = 3'd4,
    PH_PRESSEND = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] time_ms;
    logic [6:0]  raw_levels;
  } tick_item_t;

  typedef struct packed {
    event_t shift_event;
    event_t north_event;
    event_t south_event;
    event_t east_event;
    event_t west_event;
    event_t focus_up_event;
    event_t focus_down_event;
    logic   any_event;
    logic   shift_first;
  } event_item_t;

  // Per-lane control for one cycle.
  typedef struct packed {
    logic                tick;        // tick transaction accepted
    logic                menu_enter;  // menu-mode entry accepted
    logic [REF_BITS-1:0] deb_ref;
    logic [WIN_BITS-1:0] click_w;
    logic [WIN_BITS-1:0] press_w;
  } lane_ctrl_t;

  function automatic logic [REF_BITS-1:0] ref_for_speed(input logic [1:0] speed);
    logic [REF_BITS-1:0] r;
    unique case (speed)
      SPEED_SLOW:   r = REF_SLOW;
      SPEED_MEDIUM: r = REF_MEDIUM;
      default:      r = REF_FAST;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bclp_lane.sv @@
// One button lane: debounce filter plus click / long-press phase machine.
// Depends on bclp_pkg.
`default_nettype none

module bclp_lane #(
  parameter int TIME_BITS = 32
) (
  input  wire                    clk,
  input  wire                    rst,
  input  bclp_pkg::lane_ctrl_t   ctrl,
  input  wire [TIME_BITS-1:0]    now,
  input  wire                    raw_level,
  output bclp_pkg::event_t       ev
);
  import bclp_pkg::*;

  phase_t               phase, phase_next;
  logic [1:0]           click_count, click_count_next;
  logic [TIME_BITS-1:0] press_start, press_start_next;
  logic [TIME_BITS-1:0] debounce_time, debounce_time_next;
  logic                 stable_level, stable_level_next;
  logic                 last_raw, last_raw_next;
  logic                 ignore, ignore_next;

  logic                 raw_eff;
  logic [TIME_BITS-1:0] deb_elapsed;
  logic [TIME_BITS-1:0] held_time;

  always_comb begin
    phase_next         = phase;
    click_count_next   = click_count;
    press_start_next   = press_start;
    debounce_time_next = debounce_time;
    stable_level_next  = stable_level;
    last_raw_next      = last_raw;
    ignore_next        = ignore;
    ev                 = EV_NONE;

    // masked until first seen released after menu entry
    raw_eff     = raw_level && !ignore;
    deb_elapsed = now - debounce_time;
    held_time   = now - press_start;

    if (ctrl.tick) begin
      if (ignore && !raw_level) begin
        ignore_next = 1'b0;
      end

      if (last_raw == raw_eff) begin
        if (deb_elapsed >= TIME_BITS'(ctrl.deb_ref)) begin
          stable_level_next = raw_eff;
        end
      end else begin
        debounce_time_next = now;
        last_raw_next      = raw_eff;
      end

      unique case (phase)
        PH_IDLE: begin
          if (stable_level_next) begin
            phase_next       = PH_DOWN;
            press_start_next = now;
            click_count_next = 2'd0;
          end
        end
        PH_DOWN: begin
          if (!stable_level_next) begin
            phase_next       = PH_UP;
            press_start_next = now;
          end else if (held_time > TIME_BITS'(ctrl.press_w)) begin
            ev         = EV_LPSTART;
            phase_next = PH_PRESS;
          end
        end
        PH_UP: begin
          if (click_count != 2'd3) begin
            click_count_next = click_count + 2'd1;
          end
          phase_next = PH_COUNT;
        end
        PH_COUNT: begin
          if (stable_level_next) begin
            phase_next       = PH_DOWN;
            press_start_next = now;
          end else if (held_time >= TIME_BITS'(ctrl.click_w) || click_count[1]) begin
            if (click_count == 2'd1) begin
              ev = EV_CLICK;
            end else if (click_count == 2'd2) begin
              ev = EV_DOUBLE;
            end
            phase_next       = PH_IDLE;
            click_count_next = 2'd0;
            press_start_next = now;
          end
        end
        PH_PRESS: begin
          if (!stable_level_next) begin
            phase_next = PH_PRESSEND;
          end else begin
            ev = EV_LP;
          end
        end
        PH_PRESSEND: begin
          ev               = EV_LPSTOP;
          phase_next       = PH_IDLE;
          click_count_next = 2'd0;
          press_start_next = now;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end else if (ctrl.menu_enter) begin
      phase_next       = PH_IDLE;
      click_count_next = 2'd0;
      ignore_next      = ignore || raw_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      click_count   <= 2'd0;
      press_start   <= '0;
      debounce_time <= '0;
      stable_level  <= 1'b0;
      last_raw      <= 1'b0;
      ignore        <= 1'b0;
    end else begin
      phase         <= phase_next;
      click_count   <= click_count_next;
      press_start   <= press_start_next;
      debounce_time <= debounce_time_next;
      stable_level  <= stable_level_next;
      last_raw      <= last_raw_next;
      ignore        <= ignore_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bclp_merge.sv @@
// Merge stage: combines lane events into one result transaction.
// Depends on bclp_pkg.
`default_nettype none

module bclp_merge (
  input  bclp_pkg::event_t      lane_ev [bclp_pkg::NUM_BUTTONS],
  input  wire                   is_tick,
  output bclp_pkg::event_item_t result
);
  import bclp_pkg::*;

  logic any;

  always_comb begin
    any = 1'b0;
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      any = any || (lane_ev[k] != EV_NONE);
    end

    result = '0;
    if (is_tick) begin
      result.any_event   = any;
      result.shift_first = (lane_ev[0] != EV_NONE);
      result.shift_event = lane_ev[0];
      // opposing pairs cancel when they report the same event
      if (lane_ev[1] != lane_ev[2]) begin
        result.north_event = lane_ev[1];
        result.south_event = lane_ev[2];
      end
      if (lane_ev[3] != lane_ev[4]) begin
        result.east_event = lane_ev[3];
        result.west_event = lane_ev[4];
      end
      if (lane_ev[5] != lane_ev[6]) begin
        result.focus_up_event   = lane_ev[5];
        result.focus_down_event = lane_ev[6];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/button_click_longpress_detector.sv @@
// Top level of the seven-button keypad event detector.
// Depends on bclp_pkg, bclp_lane, bclp_merge and the assertion macro header.
//
// Usage:
//   tick channel (tick_valid/tick_ready/tick_item): one transaction per
//     millisecond sample, carrying op, time_ms and the seven raw levels.
//     op tick runs every lane; op menu / controller latches the tick
//     reference from button_speed and switches mode (menu entry also
//     idles every lane and masks buttons still held).
//   event channel (event_valid/event_ready/event_item): exactly one
//     result transaction per tick transaction, in order. Mode
//     transactions return an all-zero result.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes button_speed;
//     always ready. Takes effect at the next mode entry.
// The result is registered in the cycle after the tick is accepted.
// Throughput: one transaction per cycle; all seven lanes update in the
//   accept cycle and the merge stage feeds the output register directly.
// Stall: tick_ready drops while a result waits and event_ready is low;
//   the held result stays put until taken.
// Reset (rst, synchronous): lanes idle and released, controller mode,
//   speed medium, tick reference 30 ms, no result pending.
`default_nettype none
`include "button_click_longpress_detector_macros.svh"

module button_click_longpress_detector #(
  parameter int TIME_BITS = 32
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    tick_valid,
  output logic                   tick_ready,
  input  bclp_pkg::tick_item_t   tick_item,
  output logic                   event_valid,
  input  wire                    event_ready,
  output bclp_pkg::event_item_t  event_item,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire [1:0]              cfg_data
);
  import bclp_pkg::*;

  logic [1:0]          button_speed;
  logic                menu_mode;
  logic [REF_BITS-1:0] tick_ref;

  logic                 accept;
  logic                 is_menu, is_ctrl, is_tick;
  logic [TIME_BITS-1:0] now;
  lane_ctrl_t           ctrl_shift, ctrl_dir;
  event_t               lane_ev [NUM_BUTTONS];
  event_item_t          merged;

  assign cfg_ready  = 1'b1;
  // output register frees up as the held result is taken
  assign tick_ready = !event_valid || event_ready;
  assign accept     = tick_valid && tick_ready;

  assign is_menu = (tick_item.op == OP_MENU);
  assign is_ctrl = (tick_item.op == OP_CTRL);
  assign is_tick = !is_menu && !is_ctrl;
  assign now     = TIME_BITS'(tick_item.time_ms);

  // Shift always uses the reference-based windows; direction and focus
  // buttons switch to the short fixed window in controller mode.
  always_comb begin
    ctrl_shift.tick       = accept && is_tick;
    ctrl_shift.menu_enter = accept && is_menu;
    ctrl_shift.deb_ref    = tick_ref;
    ctrl_shift.click_w    = WIN_BITS'(tick_ref) << 2;
    ctrl_shift.press_w    = WIN_BITS'(tick_ref) << 3;

    ctrl_dir = ctrl_shift;
    if (!menu_mode) begin
      ctrl_dir.click_w = CTRL_WINDOW;
      ctrl_dir.press_w = CTRL_WINDOW;
    end
  end

  for (genvar k = 0; k < NUM_BUTTONS; k++) begin : g_lane
    bclp_lane #(
      .TIME_BITS (TIME_BITS)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      ((k == 0) ? ctrl_shift : ctrl_dir),
      .now       (now),
      .raw_level (tick_item.raw_levels[k]),
      .ev        (lane_ev[k])
    );
  end

  bclp_merge u_merge (
    .lane_ev (lane_ev),
    .is_tick (is_tick),
    .result  (merged)
  );

  // config register and mode state
  always_ff @(posedge clk) begin
    if (rst) begin
      button_speed <= SPEED_MEDIUM;
      menu_mode    <= 1'b0;
      tick_ref     <= REF_MEDIUM;
    end else begin
      if (cfg_valid && cfg_ready) begin
        button_speed <= cfg_data;
      end
      if (accept && !is_tick) begin
        tick_ref  <= ref_for_speed(button_speed);
        menu_mode <= is_menu;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (accept) begin
      event_valid <= 1'b1;
    end else if (event_ready) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_item <= merged;
    end
  end

  // mode transactions produce an all-zero result next cycle
  `BCLP_ASSERT_NEXT(a_mode_zero, clk, rst, accept && (is_menu || is_ctrl), event_valid && (event_item == '0), "mode transaction gave nonzero result")
  // an accepted tick always leaves a pending result
  `BCLP_ASSERT_NEXT(a_result_pending, clk, rst, accept, event_valid, "accepted transaction produced no result")
  // shift_first implies any_event and a shift event
  `BCLP_ASSERT_NOW(a_shift_first, clk, rst, event_valid && event_item.shift_first, event_item.any_event && (event_item.shift_event != EV_NONE), "shift_first without shift event")
  // a surviving north event never equals south
  `BCLP_ASSERT_NOW(a_pair_cancel, clk, rst, event_valid && (event_item.north_event != EV_NONE), event_item.north_event != event_item.south_event, "opposing pair not cancelled")
  // latched reference is always a legal speed value
  `BCLP_ASSERT_NOW(a_tick_ref, clk, rst, 1'b1, (tick_ref == REF_SLOW) || (tick_ref == REF_MEDIUM) || (tick_ref == REF_FAST), "tick reference out of range")

endmodule

`default_nettype wire

@@ verif/bclp_tb_pkg.sv @@
`timescale 1ns / 100ps
// Keypad event tracker for the keypad event detector testbench.
// Depends on bclp_pkg for the tick/event transaction types and codes.

package bclp_tb_pkg;
  import bclp_pkg::*;

  // Codes the RTL package leaves unnamed.
  localparam logic [1:0] OP_SPARE    = 2'd3;  // behaves as a tick
  localparam logic [1:0] SPEED_FAST  = 2'd2;
  localparam logic [1:0] SPEED_SPARE = 2'd3;  // falls back to the fast reference

  localparam int BTN_SHIFT      = 0;
  localparam int BTN_NORTH      = 1;
  localparam int BTN_SOUTH      = 2;
  localparam int BTN_EAST       = 3;
  localparam int BTN_WEST       = 4;
  localparam int BTN_FOCUS_UP   = 5;
  localparam int BTN_FOCUS_DOWN = 6;

  localparam int BASE_REF_MS    = 20;
  localparam int CTRL_WINDOW_MS = 5;
  localparam int CLICK_MULT     = 4;
  localparam int PRESS_MULT     = 8;
  localparam int MAX_CLICKS     = 3;

  class keypad_tracker;
    logic [1:0]  speed;
    logic [31:0] ref_ms;
    bit          menu_mode;
    phase_t      phase [NUM_BUTTONS];
    logic [31:0] press_t [NUM_BUTTONS];
    logic [31:0] bounce_t [NUM_BUTTONS];
    int          clicks [NUM_BUTTONS];
    bit          stable [NUM_BUTTONS];
    bit          last_raw [NUM_BUTTONS];
    bit          masked [NUM_BUTTONS];
    event_item_t due_reports [$];
    int          errors;
    int          matched;
    int          hits [6];

    function new();
      speed     = SPEED_MEDIUM;
      ref_ms    = speed_ms(SPEED_MEDIUM);
      menu_mode = 1'b0;
      errors    = 0;
      matched   = 0;
      foreach (hits[i]) hits[i] = 0;
      for (int k = 0; k < NUM_BUTTONS; k++) begin
        phase[k]    = PH_IDLE;
        press_t[k]  = '0;
        bounce_t[k] = '0;
        clicks[k]   = 0;
        stable[k]   = 1'b0;
        last_raw[k] = 1'b0;
        masked[k]   = 1'b0;
      end
    endfunction

    function logic [31:0] speed_ms(logic [1:0] s);
      if (s == SPEED_SLOW) return 32'(BASE_REF_MS * 2);
      if (s == SPEED_MEDIUM) return 32'(BASE_REF_MS * 3 / 2);
      return 32'(BASE_REF_MS);
    endfunction

    function void write_speed(logic [1:0] s);
      speed = s;
    endfunction

    // Debounce plus the six-phase click / long-press machine of one button.
    function event_t button_step(int k, bit raw, logic [31:0] now);
      logic [31:0] click_w, press_w, held;
      event_t ev;
      ev      = EV_NONE;
      click_w = ref_ms * CLICK_MULT;
      press_w = ref_ms * PRESS_MULT;
      if (k != BTN_SHIFT && !menu_mode) begin
        click_w = CTRL_WINDOW_MS;
        press_w = CTRL_WINDOW_MS;
      end
      if (last_raw[k] == raw) begin
        if (now - bounce_t[k] >= ref_ms) stable[k] = raw;
      end else begin
        bounce_t[k] = now;
        last_raw[k] = raw;
      end
      held = now - press_t[k];
      case (phase[k])
        PH_IDLE: begin
          if (stable[k]) begin
            phase[k]   = PH_DOWN;
            press_t[k] = now;
            clicks[k]  = 0;
          end
        end
        PH_DOWN: begin
          if (!stable[k]) begin
            phase[k]   = PH_UP;
            press_t[k] = now;
          end else if (held > press_w) begin
            ev       = EV_LPSTART;
            phase[k] = PH_PRESS;
          end
        end
        PH_UP: begin
          if (clicks[k] < MAX_CLICKS) clicks[k]++;
          phase[k] = PH_COUNT;
        end
        PH_COUNT: begin
          if (stable[k]) begin
            phase[k]   = PH_DOWN;
            press_t[k] = now;
          end else if (held >= click_w || clicks[k] >= 2) begin
            if (clicks[k] == 1) ev = EV_CLICK;
            else if (clicks[k] == 2) ev = EV_DOUBLE;
            phase[k]   = PH_IDLE;
            clicks[k]  = 0;
            press_t[k] = now;
          end
        end
        PH_PRESS: begin
          if (!stable[k]) phase[k] = PH_PRESSEND;
          else ev = EV_LP;
        end
        PH_PRESSEND: begin
          ev         = EV_LPSTOP;
          phase[k]   = PH_IDLE;
          clicks[k]  = 0;
          press_t[k] = now;
        end
        default: phase[k] = PH_IDLE;
      endcase
      return ev;
    endfunction

    // Accepted tick-channel transaction: advance the keypad, queue its report.
    function void take_sample(tick_item_t it);
      event_t      ev [NUM_BUTTONS];
      event_item_t rep;
      bit          raw;
      rep = '0;
      if (it.op == OP_MENU || it.op == OP_CTRL) begin
        ref_ms    = speed_ms(speed);
        menu_mode = (it.op == OP_MENU);
        if (menu_mode)
          for (int k = 0; k < NUM_BUTTONS; k++) begin
            phase[k]  = PH_IDLE;
            clicks[k] = 0;
            if (it.raw_levels[k]) masked[k] = 1'b1;
          end
        due_reports.push_back(rep);
        return;
      end
      for (int k = 0; k < NUM_BUTTONS; k++) begin
        raw = it.raw_levels[k];
        if (masked[k]) begin
          if (!raw) masked[k] = 1'b0;
          else raw = 1'b0;
        end
        ev[k] = button_step(k, raw, it.time_ms);
        hits[int'(ev[k])]++;
        if (ev[k] != EV_NONE) rep.any_event = 1'b1;
      end
      rep.shift_first = (ev[BTN_SHIFT] != EV_NONE);
      for (int k = BTN_NORTH; k < NUM_BUTTONS; k += 2)
        if (ev[k] == ev[k+1]) begin
          ev[k]   = EV_NONE;
          ev[k+1] = EV_NONE;
        end
      rep.shift_event      = ev[BTN_SHIFT];
      rep.north_event      = ev[BTN_NORTH];
      rep.south_event      = ev[BTN_SOUTH];
      rep.east_event       = ev[BTN_EAST];
      rep.west_event       = ev[BTN_WEST];
      rep.focus_up_event   = ev[BTN_FOCUS_UP];
      rep.focus_down_event = ev[BTN_FOCUS_DOWN];
      due_reports.push_back(rep);
    endfunction

    function void compare_field(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Accepted event-channel transaction: compare with the oldest due report.
    function void match_report(event_item_t got);
      event_item_t want;
      if (due_reports.size() == 0) begin
        $display("%0t: stray report, expected nothing, got %h", $time, got);
        errors++;
        return;
      end
      want = due_reports.pop_front();
      matched++;
      compare_field("shift_event", want.shift_event, got.shift_event);
      compare_field("north_event", want.north_event, got.north_event);
      compare_field("south_event", want.south_event, got.south_event);
      compare_field("east_event", want.east_event, got.east_event);
      compare_field("west_event", want.west_event, got.west_event);
      compare_field("focus_up_event", want.focus_up_event, got.focus_up_event);
      compare_field("focus_down_event", want.focus_down_event, got.focus_down_event);
      compare_field("any_event", want.any_event, got.any_event);
      compare_field("shift_first", want.shift_first, got.shift_first);
    endfunction
  endclass

endpackage

@@ verif/button_click_longpress_detector_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for button_click_longpress_detector (instance u_top).
// Depends on bclp_pkg and bclp_tb_pkg (keypad_tracker); drives all three channels.

module button_click_longpress_detector_tb;
  import bclp_pkg::*;
  import bclp_tb_pkg::*;

  localparam int  PERIOD       = 4;
  localparam int  RESET_CYCLES = 2;
  localparam int  NUM_PHASES   = 6;
  localparam int  PHASE_ITEMS  = 237;        // random ticks per speed setting
  localparam int  SETTLE       = 8;          // margin for the registered result
  localparam int  TIMEOUT_NS   = 2_000_000;  // far past the worst case

  localparam logic [6:0] MASK_SHIFT = 7'(1 << BTN_SHIFT);
  localparam logic [6:0] MASK_NORTH = 7'(1 << BTN_NORTH);
  localparam logic [6:0] MASK_EAST  = 7'(1 << BTN_EAST);
  localparam logic [6:0] MASK_FUP   = 7'(1 << BTN_FOCUS_UP);
  localparam logic [6:0] MASK_ALL   = 7'h7F;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        tick_valid = 1'b0;
  logic        tick_ready;
  tick_item_t  tick_item = '0;
  logic        event_valid;
  logic        event_ready = 1'b0;
  event_item_t event_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;

  keypad_tracker keypad;

  // Stimulus state: running timestamp and the held level of each button.
  logic [31:0] now_ms = '0;
  logic [6:0]  levels = '0;
  int          hold_left [NUM_BUTTONS];
  bit          mirror_pairs = 1'b0;  // opposing buttons move together
  bit          tx_free = 1'b0;       // sender never idles
  bit          rx_free = 1'b0;       // receiver never stalls
  int          rx_stall = 0;
  int          sent = 0;
  int          directed = 0;

  button_click_longpress_detector u_top (
    .clk         (clk),
    .rst         (rst),
    .tick_valid  (tick_valid),
    .tick_ready  (tick_ready),
    .tick_item   (tick_item),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_item  (event_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Receiver back-pressure: mostly ready, short stalls, the odd long one.
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      event_ready = 1'b0;
      rx_stall--;
    end else if (rx_free || $urandom_range(99) < 65) begin
      event_ready = 1'b1;
    end else begin
      event_ready = 1'b0;
      rx_stall = ($urandom_range(19) == 0) ? $urandom_range(40, 12) : $urandom_range(3);
    end
  end

  // All handshakes are observed here, on pre-edge values.
  // Report check runs first: a report never belongs to a tick taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (event_valid && event_ready) keypad.match_report(event_item);
      if (tick_valid && tick_ready) keypad.take_sample(tick_item);
      if (cfg_valid && cfg_ready) keypad.write_speed(cfg_data);
    end
  end

  // One tick-channel transaction, after a random idle gap; returns at the accepting edge.
  task automatic send_item(input logic [1:0] op, input logic [31:0] t, input logic [6:0] raw);
    int gap;
    gap = 0;
    if (!tx_free && $urandom_range(99) >= 55)
      gap = ($urandom_range(24) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    repeat (gap) begin
      @(negedge clk);
      tick_valid = 1'b0;
    end
    @(negedge clk);
    tick_valid = 1'b1;
    tick_item  = '{op: op, time_ms: t, raw_levels: raw};
    @(posedge clk);
    while (!tick_ready) @(posedge clk);
    sent++;
  endtask

  // Directed step: advance the clock of the keypad by dt ms, then send.
  task automatic step_ms(input logic [1:0] op, input int dt, input logic [6:0] raw);
    now_ms += dt;
    send_item(op, now_ms, raw);
  endtask

  // Hold off the sender until every queued report has come back.
  task automatic drain();
    @(negedge clk);
    tick_valid = 1'b0;
    while (keypad.due_reports.size() != 0) @(negedge clk);
  endtask

  // Only called with the block idle (after drain).
  task automatic write_speed(input logic [1:0] s);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold time for the next level of a button: bounce, click-length or long.
  function automatic int pick_hold(input bit pressed);
    int r;
    r = $urandom_range(99);
    if (r < 8) return $urandom_range(12, 1);
    if (pressed) return (r < 60) ? $urandom_range(160, 30) : $urandom_range(900, 250);
    return (r < 50) ? $urandom_range(120, 20) : $urandom_range(700, 150);
  endfunction

  task automatic advance_buttons(input int dt);
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      hold_left[k] -= dt;
      if (hold_left[k] <= 0) begin
        levels[k]    = ~levels[k];
        hold_left[k] = pick_hold(levels[k]);
      end
    end
    // Mirrored pairs produce equal events, which the block must cancel.
    if (mirror_pairs)
      for (int k = BTN_NORTH; k < NUM_BUTTONS; k += 2) begin
        levels[k+1]    = levels[k];
        hold_left[k+1] = hold_left[k];
      end
  endtask

  initial begin
    int            dt, r;
    logic [1:0]    phase_speed [NUM_PHASES];
    phase_speed = '{SPEED_SLOW, SPEED_FAST, SPEED_SPARE, SPEED_MEDIUM, SPEED_SLOW,
                    SPEED_FAST};
    keypad = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- Directed part: reset speed (30 ms ref), controller mode ----
    // Time extremes; all buttons pressed across the 32-bit wrap.
    now_ms = '0;
    step_ms(OP_TICK, 0, '0);
    now_ms = 32'hFFFF_FFFF;
    step_ms(OP_TICK, 0, MASK_ALL);
    step_ms(OP_TICK, 40, MASK_ALL);   // debounced, every lane goes down
    // Direction buttons pass the 5 ms press window together: equal
    // long-press events on each pair cancel, any_event still set.
    step_ms(OP_TICK, 10, MASK_ALL);
    step_ms(OP_TICK, 10, MASK_ALL);
    step_ms(OP_TICK, 5, '0);
    step_ms(OP_TICK, 40, '0);         // release seen: shift up, others press end
    step_ms(OP_TICK, 5, '0);          // long-press stops, again cancelled
    step_ms(OP_TICK, 200, '0);        // shift click window expires: single click
    // North and east long press without partners: nothing cancels.
    step_ms(OP_TICK, 5, MASK_NORTH | MASK_EAST);
    step_ms(OP_TICK, 35, MASK_NORTH | MASK_EAST);
    step_ms(OP_TICK, 10, MASK_NORTH);
    step_ms(OP_TICK, 5, '0);
    step_ms(OP_TICK, 35, '0);
    step_ms(OP_TICK, 5, '0);
    // Shift pressed in quick succession: the second release is too short to
    // pass debounce, so the count reaches two and the menu entry below idles
    // the lane first; the click sequence ends with no event.
    step_ms(OP_TICK, 50, MASK_SHIFT);
    step_ms(OP_TICK, 35, MASK_SHIFT);
    step_ms(OP_TICK, 10, '0);
    step_ms(OP_TICK, 35, '0);
    step_ms(OP_TICK, 5, MASK_SHIFT);
    step_ms(OP_TICK, 35, MASK_SHIFT);
    step_ms(OP_TICK, 10, '0);
    step_ms(OP_TICK, 35, MASK_SHIFT); // release not yet debounced, re-press restarts debounce
    step_ms(OP_TICK, 35, MASK_SHIFT); // held again: shift stays down
    step_ms(OP_TICK, 10, '0);
    step_ms(OP_TICK, 35, '0);
    step_ms(OP_TICK, 5, '0);
    // Unused speed code, menu entry with shift and focus+ still held:
    // both are masked until their raw level is seen released.
    drain();
    write_speed(SPEED_SPARE);
    step_ms(OP_MENU, 20, MASK_SHIFT | MASK_FUP);
    step_ms(OP_TICK, 30, MASK_SHIFT | MASK_FUP);
    step_ms(OP_TICK, 30, MASK_FUP);
    step_ms(OP_SPARE, 5, '0);         // spare op code runs as a tick
    step_ms(OP_SPARE, 30, MASK_FUP);
    step_ms(OP_CTRL, 30, '0);
    directed = sent;
    drain();

    // ---- Random part: one speed setting per phase ----
    levels = '0;
    foreach (hold_left[k]) hold_left[k] = pick_hold(1'b0);
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_speed(phase_speed[p]);
      tx_free      = (p == 1) || ($urandom_range(3) == 0);
      rx_free      = (p == 1) || ($urandom_range(3) == 0);
      mirror_pairs = $urandom_range(1);
      // Mode entry latches the new speed; menu entry may mask held buttons.
      send_item($urandom_range(1) ? OP_MENU : OP_CTRL, now_ms, levels);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) drain();
        r  = $urandom_range(99);
        dt = ($urandom_range(9) == 0) ? $urandom_range(60, 16) : $urandom_range(15, 1);
        now_ms += dt;
        advance_buttons(dt);
        if (r == 0)
          send_item(OP_MENU, now_ms, levels);
        else if (r == 1)
          send_item(OP_CTRL, now_ms, levels);
        else if (r < 4)
          send_item(OP_SPARE, now_ms, levels);
        else if (r < 9)
          send_item(OP_TICK, now_ms, 7'($urandom));   // noise on the levels
        else if (r == 9) begin
          now_ms = $urandom;                          // arbitrary clock jump
          send_item(OP_TICK, now_ms, levels);
        end else
          send_item(OP_TICK, now_ms, levels);
      end
      drain();
    end

    // Anything arriving now would be a stray report.
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d tick transactions (%0d directed) over %0d speed settings; %0d reports checked.",
             sent, directed, NUM_PHASES + 1, keypad.matched);
    $display("Events predicted: %0d clicks, %0d doubles, %0d lp starts, %0d lp, %0d lp stops.",
             keypad.hits[EV_CLICK], keypad.hits[EV_DOUBLE], keypad.hits[EV_LPSTART],
             keypad.hits[EV_LP], keypad.hits[EV_LPSTOP]);
    if (keypad.errors == 0 && keypad.due_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_NS);
    $display("Watchdog expired at %0t with %0d reports outstanding.", $time,
             keypad.due_reports.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
